FILE: rtl/swab_pkg.sv
// ---------------------------------------------------------------------------
// swab_pkg
// Shared widths, record layouts and codes of the sensor window averager.
// ---------------------------------------------------------------------------
`default_nettype none

package swab_pkg;

    localparam int MAX_WINDOW = 64;

    localparam int PTR_W  = $clog2(MAX_WINDOW);
    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int CFG_W  = 7;
    localparam int CMP_W  = (CFG_W > CNT_W) ? CFG_W : CNT_W;

    localparam int TEMP_W = 15;
    localparam int HUM_W  = 14;
    localparam int TIME_W = 32;
    localparam int SUM_W  = TEMP_W + PTR_W;
    localparam int STEP_W = $clog2(SUM_W);

    localparam logic [CFG_W-1:0] WIN_LEN_RESET = CFG_W'(64);

    localparam logic [SUM_W-1:0]  TEMP_MIN_MAG = SUM_W'(2 ** (TEMP_W - 1));
    localparam logic [SUM_W-1:0]  TEMP_MAX     = SUM_W'(2 ** (TEMP_W - 1) - 1);
    localparam logic [SUM_W-1:0]  HUM_MAX      = SUM_W'(2 ** HUM_W - 1);

    localparam logic OP_STORE = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    localparam logic [1:0] ST_VALID    = 2'd0;
    localparam logic [1:0] ST_NOT_FULL = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;

    typedef struct packed {
        logic [TIME_W-1:0]        stamp;
        logic [HUM_W-1:0]         hum;
        logic signed [TEMP_W-1:0] temp;
    } t_entry;

    typedef struct packed {
        logic [CNT_W-1:0]         fill_count;
        logic [TIME_W-1:0]        newest_time;
        logic [HUM_W-1:0]         newest_humidity;
        logic signed [TEMP_W-1:0] newest_temperature;
        logic [HUM_W-1:0]         mean_humidity;
        logic signed [TEMP_W-1:0] mean_temperature;
    } t_out;

    localparam int ENTRY_W     = $bits(t_entry);
    localparam int OUT_W       = $bits(t_out);
    localparam int IN_TDATA_W  = ((ENTRY_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

endpackage

`default_nettype wire

FILE: rtl/sensor_window_average_buffer_unit.sv
// ---------------------------------------------------------------------------
// sensor_window_average_buffer_unit
// Moving average over a circular store of temperature/humidity samples.
//
// Input stream: s_tuser selects store (0) or clear (1); s_tdata carries the
// sample. Every request yields exactly one result on the output stream,
// m_tuser giving the status (valid, window not full, empty).
// One request is worked on at a time; s_tready is high while the unit waits
// for work. A clear goes straight to S_OUT, a store into a window that is
// not yet full passes S_UPD first, and a store that fills the window passes
// S_UPD, S_STT/S_WTT and S_STH/S_WTH, where the serial divider computes the
// two means one after the other. The output register holds a finished
// result while the receiver stalls, and the next request is taken meanwhile;
// its result waits until the register is free. The window length is written
// through i_cfg_we/i_cfg_wdata; the user must do so only while idle, which
// the unit does not enforce. It is saturated to 1..64. Reset empties the
// window and sets the length to 64; the sample memory itself is not cleared.
// ---------------------------------------------------------------------------
`default_nettype none

module sensor_window_average_buffer_unit (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [swab_pkg::CFG_W-1:0]       i_cfg_wdata,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // [14:0] temperature, [28:15] humidity, [60:29] timestamp
    input  wire logic [swab_pkg::IN_TDATA_W-1:0]  s_tdata,
    // [0] opcode
    input  wire logic                             s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [14:0] mean_temperature, [28:15] mean_humidity, [43:29] newest_temperature,
    // [57:44] newest_humidity, [89:58] newest_time, [96:90] fill_count
    output logic [swab_pkg::OUT_TDATA_W-1:0]      m_tdata,
    // [1:0] status
    output logic [1:0]                            m_tuser
);

    localparam int SW = swab_pkg::SUM_W;
    localparam int CW = swab_pkg::CNT_W;
    localparam int PW = swab_pkg::PTR_W;
    localparam int TW = swab_pkg::TEMP_W;
    localparam int HW = swab_pkg::HUM_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_UPD  = 3'd1;
    localparam logic [2:0] S_STT  = 3'd2;
    localparam logic [2:0] S_WTT  = 3'd3;
    localparam logic [2:0] S_STH  = 3'd4;
    localparam logic [2:0] S_WTH  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]                   r_state;
    logic [2:0]                   n_state;
    logic [swab_pkg::CFG_W-1:0]   r_win_len;
    logic [PW-1:0]                r_wp;
    logic [PW-1:0]                n_wp;
    logic [CW-1:0]                r_cnt;
    logic [CW-1:0]                n_cnt;
    logic signed [SW-1:0]         r_tsum;
    logic signed [SW-1:0]         n_tsum;
    logic signed [SW-1:0]         r_hsum;
    logic signed [SW-1:0]         n_hsum;
    logic                         r_m_valid;
    swab_pkg::t_out               r_m_data;
    logic [1:0]                   r_m_status;

    swab_pkg::t_entry             r_in;
    swab_pkg::t_entry             w_rd;
    logic [1:0]                   r_res_st;
    logic signed [TW-1:0]         r_res_mt;
    logic [HW-1:0]                r_res_mh;

    logic                         w_in_acc;
    logic                         w_out_load;
    logic [swab_pkg::CMP_W-1:0]   w_len_ext;
    logic [CW-1:0]                w_len;
    logic                         w_evict;
    logic signed [SW-1:0]         w_old_t;
    logic signed [SW-1:0]         w_old_h;
    logic [PW:0]                  w_nxt;
    logic                         w_wrap;

    logic                         w_div_start;
    logic [SW-1:0]                w_div_dvd;
    logic                         w_div_done;
    logic [SW-1:0]                w_quo;
    logic [SW-1:0]                w_neg_quo;
    logic signed [TW-1:0]         w_mt;
    logic [HW-1:0]                w_mh;

    assign s_tready   = (r_state == S_IDLE);
    assign w_in_acc   = s_tvalid && s_tready;
    assign w_out_load = (r_state == S_OUT) && (!r_m_valid || m_tready);

    always_comb begin
        w_len_ext = swab_pkg::CMP_W'(r_win_len);
        if (w_len_ext == '0) begin
            w_len = CW'(1);
        end else if (w_len_ext > swab_pkg::CMP_W'(swab_pkg::MAX_WINDOW)) begin
            w_len = CW'(swab_pkg::MAX_WINDOW);
        end else begin
            w_len = CW'(w_len_ext);
        end
    end

    always_comb begin
        w_evict = (r_cnt >= w_len);
        w_old_t = w_evict ? SW'(w_rd.temp) : '0;
        w_old_h = w_evict ? SW'(w_rd.hum) : '0;
        n_tsum  = r_tsum - w_old_t + SW'(r_in.temp);
        n_hsum  = r_hsum - w_old_h + SW'(r_in.hum);
        w_nxt   = {1'b0, r_wp} + (PW + 1)'(1);
        w_wrap  = (CW'(w_nxt) >= w_len);
        n_wp    = w_wrap ? '0 : r_wp + PW'(1);
        n_cnt   = (r_cnt < w_len) ? r_cnt + CW'(1) : w_len;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = (s_tuser == swab_pkg::OP_CLEAR) ? S_OUT : S_UPD;
                end
            end
            S_UPD:  n_state = (n_cnt == w_len) ? S_STT : S_OUT;
            S_STT:  n_state = S_WTT;
            S_WTT:  n_state = w_div_done ? S_STH : S_WTT;
            S_STH:  n_state = S_WTH;
            S_WTH:  n_state = w_div_done ? S_OUT : S_WTH;
            S_OUT:  n_state = w_out_load ? S_IDLE : S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_div_start = (r_state == S_STT) || (r_state == S_STH);
        if (r_state == S_STT) begin
            w_div_dvd = r_tsum[SW-1] ? $unsigned(-r_tsum) : $unsigned(r_tsum);
        end else begin
            w_div_dvd = r_hsum[SW-1] ? $unsigned(-r_hsum) : $unsigned(r_hsum);
        end
    end

    always_comb begin
        w_neg_quo = ~w_quo + SW'(1);
        if (r_tsum[SW-1]) begin
            w_mt = (w_quo > swab_pkg::TEMP_MIN_MAG) ? TW'(swab_pkg::TEMP_MIN_MAG)
                                                    : TW'(w_neg_quo);
        end else begin
            w_mt = (w_quo > swab_pkg::TEMP_MAX) ? TW'(swab_pkg::TEMP_MAX) : TW'(w_quo);
        end
        if (r_hsum[SW-1]) begin
            w_mh = '0;
        end else begin
            w_mh = (w_quo > swab_pkg::HUM_MAX) ? HW'(swab_pkg::HUM_MAX) : HW'(w_quo);
        end
    end

    swab_store u_store (
        .i_clk     (i_clk),
        .i_wr_en   (r_state == S_UPD),
        .i_wr_addr (r_wp),
        .i_wr_data (r_in),
        .i_rd_en   (w_in_acc && (s_tuser == swab_pkg::OP_STORE)),
        .i_rd_addr (r_wp),
        .o_rd_data (w_rd)
    );

    swab_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dvd),
        .i_divisor  (w_len),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_win_len <= swab_pkg::WIN_LEN_RESET;
            r_wp      <= '0;
            r_cnt     <= '0;
            r_tsum    <= '0;
            r_hsum    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_win_len <= i_cfg_wdata;
            end
            if (w_in_acc && (s_tuser == swab_pkg::OP_CLEAR)) begin
                r_wp   <= '0;
                r_cnt  <= '0;
                r_tsum <= '0;
                r_hsum <= '0;
            end else if (r_state == S_UPD) begin
                r_wp   <= n_wp;
                r_cnt  <= n_cnt;
                r_tsum <= n_tsum;
                r_hsum <= n_hsum;
            end
            if (w_out_load) begin
                r_m_valid <= 1'b1;
            end else if (m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in     <= swab_pkg::t_entry'(s_tdata[swab_pkg::ENTRY_W-1:0]);
            r_res_st <= (s_tuser == swab_pkg::OP_CLEAR) ? swab_pkg::ST_EMPTY
                                                       : swab_pkg::ST_NOT_FULL;
            r_res_mt <= '0;
            r_res_mh <= '0;
        end
        if ((r_state == S_UPD) && (n_cnt == w_len)) begin
            r_res_st <= swab_pkg::ST_VALID;
        end
        if ((r_state == S_WTT) && w_div_done) begin
            r_res_mt <= w_mt;
        end
        if ((r_state == S_WTH) && w_div_done) begin
            r_res_mh <= w_mh;
        end
        if (w_out_load) begin
            r_m_status                  <= r_res_st;
            r_m_data.mean_temperature   <= r_res_mt;
            r_m_data.mean_humidity      <= r_res_mh;
            r_m_data.fill_count         <= r_cnt;
            if (r_res_st == swab_pkg::ST_EMPTY) begin
                r_m_data.newest_temperature <= '0;
                r_m_data.newest_humidity    <= '0;
                r_m_data.newest_time        <= '0;
            end else begin
                r_m_data.newest_temperature <= r_in.temp;
                r_m_data.newest_humidity    <= r_in.hum;
                r_m_data.newest_time        <= r_in.stamp;
            end
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = swab_pkg::OUT_TDATA_W'(r_m_data);
    assign m_tuser  = r_m_status;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(swab_pkg::MAX_WINDOW))
        else $error("fill count above maximum window");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && (s_tuser == swab_pkg::OP_CLEAR)
        |=> (r_cnt == '0) && (r_wp == '0) && (r_tsum == '0) && (r_hsum == '0))
        else $error("clear did not empty the window");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_WTT) || (r_state == S_WTH))
        else $error("divider finished outside a wait state");

    a_valid_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (m_tuser == swab_pkg::ST_VALID) |-> r_m_data.fill_count == w_len)
        else $error("valid status with window not full");

endmodule

`default_nettype wire

FILE: rtl/swab_store.sv
// ---------------------------------------------------------------------------
// swab_store
// Sample memory: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module swab_store (
    input  wire logic                       i_clk,
    input  wire logic                       i_wr_en,
    input  wire logic [swab_pkg::PTR_W-1:0] i_wr_addr,
    input  wire swab_pkg::t_entry           i_wr_data,
    input  wire logic                       i_rd_en,
    input  wire logic [swab_pkg::PTR_W-1:0] i_rd_addr,
    output swab_pkg::t_entry                o_rd_data
);

    swab_pkg::t_entry r_mem [swab_pkg::MAX_WINDOW];
    swab_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: rtl/swab_div.sv
// ---------------------------------------------------------------------------
// swab_div
// Serial restoring divider: one quotient bit per cycle, unsigned operands.
// ---------------------------------------------------------------------------
`default_nettype none

module swab_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [swab_pkg::SUM_W-1:0] i_dividend,
    input  wire logic [swab_pkg::CNT_W-1:0] i_divisor,
    output logic                            o_done,
    output logic [swab_pkg::SUM_W-1:0]      o_quotient
);

    localparam int SW = swab_pkg::SUM_W;
    localparam int CW = swab_pkg::CNT_W;

    logic                            r_busy;
    logic                            r_done;
    logic [swab_pkg::STEP_W-1:0]     r_step;
    logic [SW-1:0]                   r_quo;
    logic [CW-1:0]                   r_rem;
    logic [CW-1:0]                   r_dvs;

    logic [CW:0]                     w_trial;
    logic [CW:0]                     w_diff;
    logic                            w_ge;
    logic [SW-1:0]                   n_quo;
    logic [CW-1:0]                   n_rem;

    always_comb begin
        w_trial = {r_rem, r_quo[SW-1]};
        w_diff  = w_trial - {1'b0, r_dvs};
        w_ge    = (w_trial >= {1'b0, r_dvs});
        n_quo   = {r_quo[SW-2:0], w_ge};
        n_rem   = w_ge ? w_diff[CW-1:0] : w_trial[CW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= swab_pkg::STEP_W'(SW - 1);
            end else if (r_busy) begin
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step - swab_pkg::STEP_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

FILE: tb/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the sensor window averager. Directed requests hit
// the field extremes, window length saturation, truncation of negative means,
// and a window lowered without a clear, where stale sums saturate the means.
// Random requests then run through several window lengths under four
// sender/receiver idling patterns. A behavioral model in the bench predicts
// every result, and each result is compared field by field in arrival order.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;

    typedef struct packed {
        logic [1:0]       status;
        swab_pkg::t_out   data;
    } t_avg_result;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_cfg_we = 1'b0;
    logic [swab_pkg::CFG_W-1:0]         i_cfg_wdata = '0;
    logic                               s_tvalid = 1'b0;
    logic                               s_tready;
    logic [swab_pkg::IN_TDATA_W-1:0]    s_tdata = '0;
    logic                               s_tuser = 1'b0;
    logic                               m_tvalid;
    logic                               m_tready = 1'b0;
    logic [swab_pkg::OUT_TDATA_W-1:0]   m_tdata;
    logic [1:0]                         m_tuser;

    // window model
    int                         win_temp [swab_pkg::MAX_WINDOW];
    int                         win_hum [swab_pkg::MAX_WINDOW];
    int unsigned                wr_ptr = 0;
    int unsigned                fill = 0;
    longint                     tsum_model = 0;
    longint                     hum_sum = 0;
    logic [swab_pkg::CFG_W-1:0] window_cfg = swab_pkg::WIN_LEN_RESET;

    t_avg_result                results_due [$];
    int                         error_count = 0;
    int                         results_seen = 0;
    int unsigned                sender_idle_pct = 0;
    int unsigned                receiver_stall_pct = 0;

    sensor_window_average_buffer_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    initial forever #4 i_clk = ~i_clk;

    initial begin
        #12_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic t_avg_result compute_window_average(input logic op,
                                                           input swab_pkg::t_entry smp);
        int unsigned len;
        int unsigned slot;
        longint      tq;
        longint      hq;
        t_avg_result r;
        r = '0;
        if (window_cfg == 0)
            len = 1;
        else if (window_cfg > swab_pkg::MAX_WINDOW)
            len = swab_pkg::MAX_WINDOW;
        else
            len = window_cfg;
        if (op == swab_pkg::OP_CLEAR) begin
            wr_ptr     = 0;
            fill       = 0;
            tsum_model = 0;
            hum_sum    = 0;
            r.status   = swab_pkg::ST_EMPTY;
            return r;
        end
        slot = wr_ptr % swab_pkg::MAX_WINDOW;
        if (fill >= len) begin
            tsum_model -= longint'(win_temp[slot]);
            hum_sum    -= longint'(win_hum[slot]);
        end
        win_temp[slot] = int'(smp.temp);
        win_hum[slot]  = int'(smp.hum);
        tsum_model += longint'(win_temp[slot]);
        hum_sum    += longint'(win_hum[slot]);
        wr_ptr = (slot + 1 >= len) ? 0 : slot + 1;
        fill   = (fill < len) ? fill + 1 : len;
        if (fill == len) begin
            tq = tsum_model / longint'(len);
            hq = hum_sum / longint'(len);
            if (tq < -16384) tq = -16384;
            if (tq > 16383) tq = 16383;
            if (hq < 0) hq = 0;
            if (hq > 16383) hq = 16383;
            r.status = swab_pkg::ST_VALID;
            r.data.mean_temperature = tq[14:0];
            r.data.mean_humidity    = hq[13:0];
        end else begin
            r.status = swab_pkg::ST_NOT_FULL;
        end
        r.data.newest_temperature = smp.temp;
        r.data.newest_humidity    = smp.hum;
        r.data.newest_time        = smp.stamp;
        r.data.fill_count         = fill[swab_pkg::CNT_W-1:0];
        return r;
    endfunction

    function automatic swab_pkg::t_entry make_sample(input int t, input int h,
                                                     input logic [31:0] ts);
        swab_pkg::t_entry e;
        e.temp  = t[14:0];
        e.hum   = h[13:0];
        e.stamp = ts;
        return e;
    endfunction

    function automatic swab_pkg::t_entry random_sample();
        int t;
        int h;
        if ($urandom_range(3) == 0) begin
            t = int'($urandom_range(32767));
            h = int'($urandom_range(16383));
        end else begin
            t = int'($urandom_range(16500)) - 4000;
            h = int'($urandom_range(10000));
        end
        return make_sample(t, h, $urandom);
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] result %0d: %s", $realtime, results_seen, what);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h, want %h", name, got, want));
    endtask

    // receiver side
    always @(posedge i_clk)
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);

    always @(posedge i_clk) begin : check_result
        t_avg_result      want;
        swab_pkg::t_out   got;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = swab_pkg::t_out'(m_tdata[swab_pkg::OUT_W-1:0]);
            if (results_due.size() == 0) begin
                report_mismatch("result with no request pending");
            end else begin
                want = results_due.pop_front();
                check_field("status", m_tuser, want.status);
                check_field("mean_temperature", got.mean_temperature,
                            want.data.mean_temperature);
                check_field("mean_humidity", got.mean_humidity, want.data.mean_humidity);
                check_field("newest_temperature", got.newest_temperature,
                            want.data.newest_temperature);
                check_field("newest_humidity", got.newest_humidity,
                            want.data.newest_humidity);
                check_field("newest_time", got.newest_time, want.data.newest_time);
                check_field("fill_count", got.fill_count, want.data.fill_count);
            end
            results_seen++;
        end
    end

    task automatic set_idling(input int unsigned sender_pct, input int unsigned receiver_pct);
        sender_idle_pct    = sender_pct;
        receiver_stall_pct = receiver_pct;
    endtask

    task automatic send_request(input logic op, input swab_pkg::t_entry smp);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= swab_pkg::IN_TDATA_W'(smp);
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        results_due.push_back(compute_window_average(op, smp));
    endtask

    task automatic store(input swab_pkg::t_entry smp);
        send_request(swab_pkg::OP_STORE, smp);
    endtask

    task automatic clear_window();
        send_request(swab_pkg::OP_CLEAR, random_sample());
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [swab_pkg::CFG_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        window_cfg  = value;
        @(posedge i_clk);
    endtask

    task automatic test_reset_and_clear();
        set_idling(0, 0);
        store(make_sample(0, 0, 32'h0));
        clear_window();
        clear_window();
        wait_drained();
    endtask

    // length zero saturates to one: every store is a full window
    task automatic test_unit_window();
        write_window('0);
        store(make_sample(-16384, 16383, 32'hFFFF_FFFF));
        store(make_sample(16383, 0, 32'h0));
        store(make_sample(-4000, 10000, 32'h5555_AAAA));
        store(make_sample(12500, 1, 32'hAAAA_5555));
        store(make_sample(-1, 8191, 32'h8000_0001));
        wait_drained();
    endtask

    task automatic test_oversize_window();
        write_window('1);
        store(make_sample(-2, 2, 32'h1234_5678));
        wait_drained();
    endtask

    // negative means truncate toward zero
    task automatic test_short_window();
        write_window(swab_pkg::CFG_W'(3));
        clear_window();
        store(make_sample(-1, 1, 32'd1));
        store(make_sample(-1, 1, 32'd2));
        store(make_sample(0, 0, 32'd3));
        store(make_sample(5, 3, 32'd4));
        store(make_sample(-7, 9, 32'd5));
        wait_drained();
    endtask

    // shrink a full window without a clear: pointer past the end, stale sums
    task automatic test_window_lowered();
        write_window(swab_pkg::CFG_W'(6));
        clear_window();
        repeat (8) store(make_sample(-16384, 16383, $urandom));
        wait_drained();
        write_window(swab_pkg::CFG_W'(2));
        store(make_sample(16383, 16383, $urandom));
        store(make_sample(-16384, 0, $urandom));
        wait_drained();
    endtask

    // write every entry once so any later eviction reads known data
    task automatic test_fill_store();
        write_window(swab_pkg::CFG_W'(64));
        clear_window();
        repeat (swab_pkg::MAX_WINDOW) store(random_sample());
        wait_drained();
    endtask

    task automatic test_random_traffic();
        int unsigned len;
        for (int phase = 0; phase < 16; phase++) begin
            case (phase % 4)
                0: set_idling(0, 0);
                1: set_idling(80, 0);
                2: set_idling(0, 80);
                default: set_idling(25, 25);
            endcase
            case ($urandom_range(3))
                0: len = $urandom_range(1, 8);
                1: len = $urandom_range(0, 127);
                2: len = $urandom_range(9, 64);
                default: len = 64;
            endcase
            write_window(len[swab_pkg::CFG_W-1:0]);
            if ($urandom_range(1) == 0) clear_window();
            repeat (76) begin
                if ($urandom_range(149) == 0)
                    clear_window();
                else
                    store(random_sample());
            end
            wait_drained();
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_and_clear();
        test_unit_window();
        test_oversize_window();
        test_short_window();
        test_window_lowered();
        test_fill_store();
        test_random_traffic();
        set_idling(0, 0);
        repeat (60) @(posedge i_clk);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
rtl/swab_pkg.sv
rtl/swab_store.sv
rtl/swab_div.sv
rtl/sensor_window_average_buffer_unit.sv
tb/tb.sv
